// ===== hw/rtl/snvs_pkg.sv =====
// Package for the sorted nearest value search block.
// Holds default sizes, item mode codes and the structs passed between the top level and the cells.
// No dependencies.
package snvs_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MODE_W = 2;
    localparam int NEAREST_INDEX_W = 6;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic insert_en;
        logic query_en;
    } t_cell_op;

    typedef struct packed {
        logic boundary;
        logic lower;
        logic last_le;
    } t_cell_res;

endpackage

// ===== hw/rtl/snvs_if.sv =====
// Valid/ready channel interfaces for the item and result transfers.
// Depends on snvs_pkg for the mode and index widths.
interface snvs_in_if import snvs_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [MODE_W-1:0]             mode;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

interface snvs_out_if import snvs_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [NEAREST_INDEX_W-1:0] nearest_index;
    logic                       table_empty;
    logic                       overflow_seen;

    modport source (output valid, output nearest_index, output table_empty,
                    output overflow_seen, input ready);
    modport sink (input valid, input nearest_index, input table_empty,
                  input overflow_seen, output ready);
endinterface

// ===== hw/rtl/snvs_cell.sv =====
// One table cell: holds one sorted entry and compares it against the current key.
// Takes its left neighbor's entry and compare flags for shifting inserts and nearest choice.
// Depends on snvs_pkg.
module snvs_cell import snvs_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int CELL_IDX    = 0
) (
    input  logic                                 i_clk,
    input  t_cell_op                             i_op,
    input  logic signed [VALUE_WIDTH-1:0]        i_key,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]     i_count,
    input  logic signed [VALUE_WIDTH-1:0]        i_left_val,
    input  logic                                 i_left_gt,
    input  logic                                 i_left_ge,
    output logic signed [VALUE_WIDTH-1:0]        o_val,
    output logic                                 o_gt,
    output logic                                 o_ge,
    output t_cell_res                            o_res
);

    localparam int CNT_W = $clog2(TABLE_DEPTH+1);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(CELL_IDX + 1);

    logic signed [VALUE_WIDTH-1:0] r_val;
    t_cell_res                     r_res;
    t_cell_res                     n_res;
    logic                          occupied;
    logic                          write_en;
    logic signed [VALUE_WIDTH:0]   d_lo;
    logic signed [VALUE_WIDTH:0]   d_hi;

    assign occupied = MY_IDX < i_count;
    assign o_gt = occupied && (r_val > i_key);
    assign o_ge = occupied && (r_val >= i_key);
    assign o_val = r_val;
    assign o_res = r_res;

    // An insert lands in the first cell above the key, or in the first free cell.
    assign write_en = i_op.insert_en && (o_gt || (MY_IDX == i_count));

    assign d_lo = $signed({i_key[VALUE_WIDTH-1], i_key})
                - $signed({i_left_val[VALUE_WIDTH-1], i_left_val});
    assign d_hi = $signed({r_val[VALUE_WIDTH-1], r_val})
                - $signed({i_key[VALUE_WIDTH-1], i_key});

    always_comb begin
        n_res.boundary = o_ge && !i_left_ge;
        n_res.lower = n_res.boundary && (CELL_IDX != 0) && (d_lo < d_hi);
        n_res.last_le = occupied && (MY_NEXT == i_count) && !o_gt;
    end

    always_ff @(posedge i_clk) begin
        if (write_en) begin
            r_val <= i_left_gt ? i_left_val : i_key;
        end
        if (i_op.query_en) begin
            r_res <= n_res;
        end
    end

endmodule

// ===== hw/rtl/sorted_nearest_value_search.sv =====
// Sorted nearest value search: a chain of compare cells holding an ascending table.
// An insert, clear or ignored item is done in ST_EXEC, and the block then returns to ST_IDLE to
// take the next item. A query registers the cell results in ST_EXEC and its result in
// ST_RESOLVE before the next item is taken; it stays in ST_RESOLVE only while the previous
// result is still held by the output.
// Reset empties the table and clears the overflow flag; stored entries are not cleared.
module sorted_nearest_value_search import snvs_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    snvs_in_if.sink      i_in,
    snvs_out_if.source   o_out
);

    localparam int CNT_W = $clog2(TABLE_DEPTH+1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int EXT_W = IDX_W + NEAREST_INDEX_W;

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_RESOLVE} t_state;

    t_state                         r_state;
    logic [MODE_W-1:0]              r_mode;
    logic signed [VALUE_WIDTH-1:0]  r_key;
    logic [CNT_W-1:0]               r_count;
    logic                           r_ovf;
    logic                           r_out_valid;
    logic [NEAREST_INDEX_W-1:0]     r_out_index;
    logic                           r_out_empty;
    logic                           r_out_ovf;

    t_cell_op                       cell_op;
    logic                           full;
    logic signed [VALUE_WIDTH-1:0]  cell_val [TABLE_DEPTH];
    logic                           cell_gt [TABLE_DEPTH];
    logic                           cell_ge [TABLE_DEPTH];
    t_cell_res                      cell_res [TABLE_DEPTH];

    logic [IDX_W-1:0]               bnd_idx;
    logic                           lower_any;
    logic                           last_any;
    logic [CNT_W-1:0]               last_cnt;
    logic [IDX_W-1:0]               res_idx;
    logic [EXT_W-1:0]               res_ext;

    assign full = r_count == CNT_W'(TABLE_DEPTH);
    assign cell_op.insert_en = (r_state == ST_EXEC) && (r_mode == MODE_INSERT) && !full;
    assign cell_op.query_en = (r_state == ST_EXEC) && (r_mode == MODE_QUERY);

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            snvs_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .TABLE_DEPTH (TABLE_DEPTH),
                .CELL_IDX    (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_op       (cell_op),
                .i_key      (r_key),
                .i_count    (r_count),
                .i_left_val (r_key),
                .i_left_gt  (1'b0),
                .i_left_ge  (1'b0),
                .o_val      (cell_val[g]),
                .o_gt       (cell_gt[g]),
                .o_ge       (cell_ge[g]),
                .o_res      (cell_res[g])
            );
        end else begin : g_rest
            snvs_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .TABLE_DEPTH (TABLE_DEPTH),
                .CELL_IDX    (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_op       (cell_op),
                .i_key      (r_key),
                .i_count    (r_count),
                .i_left_val (cell_val[g-1]),
                .i_left_gt  (cell_gt[g-1]),
                .i_left_ge  (cell_ge[g-1]),
                .o_val      (cell_val[g]),
                .o_gt       (cell_gt[g]),
                .o_ge       (cell_ge[g]),
                .o_res      (cell_res[g])
            );
        end
    end

    // At most one cell reports the boundary, so the index is an OR over the cells.
    always_comb begin
        bnd_idx = '0;
        lower_any = 1'b0;
        last_any = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (cell_res[k].boundary) begin
                bnd_idx = bnd_idx | IDX_W'(k);
            end
            lower_any = lower_any | cell_res[k].lower;
            last_any = last_any | cell_res[k].last_le;
        end
    end

    assign last_cnt = r_count - CNT_W'(1);

    always_comb begin
        if (cell_res[0].boundary) begin
            res_idx = '0;
        end else if (last_any) begin
            res_idx = last_cnt[IDX_W-1:0];
        end else if (lower_any) begin
            res_idx = bnd_idx - IDX_W'(1);
        end else begin
            res_idx = bnd_idx;
        end
    end

    assign res_ext = EXT_W'(res_idx);

    assign i_in.ready = r_state == ST_IDLE;
    assign o_out.valid = r_out_valid;
    assign o_out.nearest_index = r_out_index;
    assign o_out.table_empty = r_out_empty;
    assign o_out.overflow_seen = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != ST_RESOLVE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_mode <= i_in.mode;
                        r_key <= i_in.value;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    case (r_mode)
                        MODE_INSERT: begin
                            if (full) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_state <= ST_IDLE;
                        end
                        MODE_CLEAR: begin
                            r_count <= '0;
                            r_state <= ST_IDLE;
                        end
                        MODE_QUERY: begin
                            r_state <= ST_RESOLVE;
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_RESOLVE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_empty <= r_count == '0;
                        r_out_index <= (r_count == '0) ? '0 : res_ext[NEAREST_INDEX_W-1:0];
                        r_out_ovf <= r_ovf;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag fell without reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_empty_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.table_empty) |-> (o_out.nearest_index == '0))
        else $error("empty table result with nonzero index");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item taken while previous item still in work");

endmodule
